/* hdl/assert_macros.svh */
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock edge, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rmh_pkg.sv */
// ----------------------------------------------------------------------------
// rmh_pkg
// Types and constants for the radial mass histogram.
// ----------------------------------------------------------------------------
package rmh_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned R2W    = 52;
  localparam int unsigned RootW  = 26;
  localparam int unsigned CntW   = 32;
  localparam int unsigned MassW  = 48;
  localparam int unsigned FrmW   = 24;
  localparam int unsigned BwW    = 24;
  localparam logic [BwW-1:0] BinWidthReset = 24'd7864;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CFG_CX = 3'd0,
    CFG_CY = 3'd1,
    CFG_CZ = 3'd2,
    CFG_BW = 3'd3,
    CFG_CUT = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_SQZ, ST_CMP, ST_SQRT, ST_DIV,
    ST_RD, ST_UPD, ST_CLR, ST_OUT, ST_INIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input beat
    logic sq_step;  // square one offset and accumulate
    logic cmp;      // cutoff compare, outlier/frame update
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic rd;       // issue store read
    logic upd;      // write updated bin / build result
    logic clr_init;
    logic clr_step;
    logic fin;      // result without a bin update (clear, unused op, add outside cutoff)
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_cut;   // r2 below the squared cutoff
    logic sqrt_done;
    logic div_done;
    logic clr_done;
  } sts_t;

endpackage

/* hdl/rmh_ctrl.sv */
// ----------------------------------------------------------------------------
// rmh_ctrl
// Sequencer for the histogram datapath.
// ----------------------------------------------------------------------------
module rmh_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_func,
  output logic            out_valid,
  input  logic            out_ready,
  output rmh_pkg::cmd_t   cmd,
  input  rmh_pkg::sts_t   sts
);

  rmh_pkg::state_t state_r, state_nxt;
  rmh_pkg::func_t  func_r, func_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmh_pkg::ST_INIT;
      func_r      <= rmh_pkg::FUNC_NOP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      func_r      <= func_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      rmh_pkg::ST_IDLE: begin
        // result register must be free (or draining) before a new op
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          func_nxt = rmh_pkg::func_t'(in_func);
          case (rmh_pkg::func_t'(in_func))
            rmh_pkg::FUNC_ADD:   state_nxt = rmh_pkg::ST_SQX;
            rmh_pkg::FUNC_READ:  state_nxt = rmh_pkg::ST_RD;
            rmh_pkg::FUNC_CLEAR: state_nxt = rmh_pkg::ST_CLR;
            default:             state_nxt = rmh_pkg::ST_OUT;
          endcase
        end
      end
      rmh_pkg::ST_SQX: begin cmd.sq_step = 1'b1; state_nxt = rmh_pkg::ST_SQY; end
      rmh_pkg::ST_SQY: begin cmd.sq_step = 1'b1; state_nxt = rmh_pkg::ST_SQZ; end
      rmh_pkg::ST_SQZ: begin cmd.sq_step = 1'b1; state_nxt = rmh_pkg::ST_CMP; end
      rmh_pkg::ST_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.in_cut) begin
          cmd.sqrt_init = 1'b1;
          state_nxt = rmh_pkg::ST_SQRT;
        end else begin
          state_nxt = rmh_pkg::ST_OUT;
        end
      end
      rmh_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) begin
          cmd.div_init = 1'b1;
          state_nxt = rmh_pkg::ST_DIV;
        end
      end
      rmh_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = rmh_pkg::ST_RD;
      end
      rmh_pkg::ST_RD: begin cmd.rd = 1'b1; state_nxt = rmh_pkg::ST_UPD; end
      rmh_pkg::ST_UPD: begin
        cmd.upd = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = rmh_pkg::ST_IDLE;
      end
      rmh_pkg::ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = rmh_pkg::ST_OUT;
      end
      rmh_pkg::ST_OUT: begin
        cmd.fin = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = rmh_pkg::ST_IDLE;
      end
      // zero the bin stores after reset, no result beat
      rmh_pkg::ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = rmh_pkg::ST_IDLE;
      end
      default: state_nxt = rmh_pkg::ST_IDLE;
    endcase
    if (state_r == rmh_pkg::ST_IDLE && in_valid && in_ready &&
        rmh_pkg::func_t'(in_func) == rmh_pkg::FUNC_CLEAR) begin
      cmd.clr_init = 1'b1;
    end
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_busy_no_ready, clk, rst_n, state_r != rmh_pkg::ST_IDLE, !in_ready, "ready while busy")
  `ASSERT_NEXT(a_upd_gives_out, clk, rst_n, state_r == rmh_pkg::ST_UPD, out_valid_r, "no result after update")
  `ASSERT_IMPL(a_clr_func, clk, rst_n, state_r == rmh_pkg::ST_CLR, func_r == rmh_pkg::FUNC_CLEAR, "clear state without clear op")

endmodule

/* hdl/rmh_dp.sv */
// ----------------------------------------------------------------------------
// rmh_dp
// Datapath: squared distance, bit-serial isqrt, restoring divide, bin stores.
// ----------------------------------------------------------------------------
module rmh_dp #(
  parameter int unsigned NUM_BINS = 256,
  parameter int unsigned BIN_AW   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rmh_pkg::cmd_t                 cmd,
  output rmh_pkg::sts_t                 sts,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic [1:0]                    in_func,
  input  logic signed [23:0]            in_pos_x,
  input  logic signed [23:0]            in_pos_y,
  input  logic signed [23:0]            in_pos_z,
  input  logic [15:0]                   in_atom_mass,
  input  logic                          in_last_in_frame,
  input  logic [7:0]                    in_read_bin,
  output logic                          out_in_range,
  output logic [7:0]                    out_bin_number,
  output logic [31:0]                   out_bin_count,
  output logic [47:0]                   out_bin_mass,
  output logic [31:0]                   out_outside_count,
  output logic [23:0]                   out_frames_seen,
  output logic                          out_bin_overflow
);

  localparam int unsigned R2W = rmh_pkg::R2W;
  localparam int unsigned RW  = rmh_pkg::RootW;
  localparam int unsigned BW  = rmh_pkg::BwW;

  // configuration
  logic signed [23:0] cx_r, cy_r, cz_r;
  logic [BW-1:0]      bw_r;
  logic [R2W-1:0]     cut_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; cz_r <= '0;
      bw_r <= rmh_pkg::BinWidthReset;
      cut_r <= '0;
    end else if (cfg_we) begin
      case (rmh_pkg::cfg_idx_t'(cfg_index))
        rmh_pkg::CFG_CX:  cx_r  <= cfg_data[23:0];
        rmh_pkg::CFG_CY:  cy_r  <= cfg_data[23:0];
        rmh_pkg::CFG_CZ:  cz_r  <= cfg_data[23:0];
        rmh_pkg::CFG_BW:  bw_r  <= cfg_data[BW-1:0];
        rmh_pkg::CFG_CUT: cut_r <= cfg_data[R2W-1:0];
        default: ;
      endcase
    end
  end

  // captured input
  logic [1:0]          func_r;
  logic signed [23:0]  px_r, py_r, pz_r;
  logic [15:0]         mass_r;
  logic                last_r;
  logic [7:0]          rbin_r;
  logic [1:0]          sq_sel_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      px_r <= in_pos_x; py_r <= in_pos_y; pz_r <= in_pos_z;
      mass_r <= in_atom_mass;
      last_r <= in_last_in_frame;
      rbin_r <= in_read_bin;
    end
  end

  // squared distance: one 25x25 square per cycle
  logic [R2W-1:0]     r2_r;
  logic signed [24:0] d;
  logic [24:0]        dabs;
  logic [49:0]        dsq;

  always_comb begin
    case (sq_sel_r)
      2'd0:    d = 25'(px_r) - 25'(cx_r);
      2'd1:    d = 25'(py_r) - 25'(cy_r);
      default: d = 25'(pz_r) - 25'(cz_r);
    endcase
    dabs = d[24] ? 25'(-d) : 25'(d);
    dsq  = dabs * dabs;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r2_r <= '0;
      sq_sel_r <= 2'd0;
    end else if (cmd.sq_step) begin
      r2_r <= r2_r + R2W'(dsq);
      sq_sel_r <= sq_sel_r + 2'd1;
    end
  end

  assign sts.in_cut = r2_r < cut_r;

  // bit-serial integer square root, two radicand bits per step
  logic [R2W-1:0] sq_rem_r;
  logic [RW-1:0]  root_r;
  logic [4:0]     sq_cnt_r;
  logic [R2W-1:0] sq_rad_r;
  logic [RW+1:0]  trial;
  logic [RW+1:0]  rem_sh;

  always_comb begin
    rem_sh = {sq_rem_r[RW-1:0], sq_rad_r[R2W-1 -: 2]};
    trial  = {root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_rem_r <= '0;
      root_r   <= '0;
      sq_rad_r <= r2_r;
      sq_cnt_r <= 5'(RW);
    end else if (cmd.sqrt_step && sq_cnt_r != 5'd0) begin
      sq_rad_r <= {sq_rad_r[R2W-3:0], 2'b00};
      sq_cnt_r <= sq_cnt_r - 5'd1;
      if (rem_sh >= trial) begin
        sq_rem_r <= R2W'(rem_sh - trial);
        root_r   <= {root_r[RW-2:0], 1'b1};
      end else begin
        sq_rem_r <= R2W'(rem_sh);
        root_r   <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  assign sts.sqrt_done = sq_cnt_r == 5'd0;

  // restoring division root / width, one quotient bit per step
  logic [RW-1:0]  quo_r;
  logic [BW:0]    drem_r;
  logic [4:0]     dv_cnt_r;
  logic [BW-1:0]  dvs_r;
  logic [BW:0]    drem_sh;

  assign drem_sh = {drem_r[BW-1:0], quo_r[RW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r   <= root_r;
      drem_r  <= '0;
      dvs_r   <= (bw_r == '0) ? BW'(1) : bw_r;
      dv_cnt_r <= 5'(RW);
    end else if (cmd.div_step && dv_cnt_r != 5'd0) begin
      dv_cnt_r <= dv_cnt_r - 5'd1;
      if (drem_sh >= {1'b0, dvs_r}) begin
        drem_r <= drem_sh - {1'b0, dvs_r};
        quo_r  <= {quo_r[RW-2:0], 1'b1};
      end else begin
        drem_r <= drem_sh;
        quo_r  <= {quo_r[RW-2:0], 1'b0};
      end
    end
  end

  assign sts.div_done = dv_cnt_r == 5'd0;

  // bin stores with clearing sweep
  logic [31:0] cnt_mem [NUM_BINS];
  logic [47:0] mass_mem [NUM_BINS];
  logic [31:0] cnt_rd_r;
  logic [47:0] mass_rd_r;
  logic [BIN_AW-1:0] addr_r;
  logic        ovf_r;
  logic [BIN_AW:0] clr_cnt_r;
  logic        is_add;
  logic [BIN_AW-1:0] wr_addr;
  logic        wr_en;
  logic [31:0] wr_cnt;
  logic [47:0] wr_mass;

  assign is_add = func_r == rmh_pkg::FUNC_ADD;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      if (is_add) begin
        addr_r <= BIN_AW'(quo_r);
        ovf_r  <= quo_r >= RW'(NUM_BINS);
        cnt_rd_r  <= cnt_mem[BIN_AW'(quo_r)];
        mass_rd_r <= mass_mem[BIN_AW'(quo_r)];
      end else begin
        addr_r <= BIN_AW'(rbin_r);
        ovf_r  <= 32'(rbin_r) >= NUM_BINS;
        cnt_rd_r  <= cnt_mem[BIN_AW'(rbin_r)];
        mass_rd_r <= mass_mem[BIN_AW'(rbin_r)];
      end
    end
  end

  // reset starts a sweep too, so the stores read as zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_init) clr_cnt_r <= '0;
    else if (cmd.clr_step && !sts.clr_done) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  assign sts.clr_done = clr_cnt_r == (BIN_AW+1)'(NUM_BINS);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_cnt  = cnt_rd_r + 32'd1;
    wr_mass = mass_rd_r + 48'(mass_r);
    if (cmd.clr_step && !sts.clr_done) begin
      wr_en = 1'b1;
      wr_addr = clr_cnt_r[BIN_AW-1:0];
      wr_cnt = '0;
      wr_mass = '0;
    end else if (cmd.upd && is_add && !ovf_r) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[wr_addr]  <= wr_cnt;
      mass_mem[wr_addr] <= wr_mass;
    end
  end

  // counters
  logic [31:0] outl_r;
  logic [23:0] frm_r;

  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.clr_init)) begin
      outl_r <= '0;
      frm_r  <= '0;
    end else if (cmd.cmp) begin
      if (!sts.in_cut) outl_r <= outl_r + 32'd1;
      if (last_r) frm_r <= frm_r + 24'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_in_range     <= is_add;
      out_bin_overflow <= ovf_r;
      out_bin_number   <= ovf_r && is_add ? 8'd0 :
                          (is_add ? 8'(addr_r) : rbin_r);
      out_bin_count    <= ovf_r ? 32'd0 : (is_add ? wr_cnt : cnt_rd_r);
      out_bin_mass     <= ovf_r ? 48'd0 : (is_add ? wr_mass : mass_rd_r);
      out_outside_count <= outl_r;
      out_frames_seen  <= frm_r;
    end else if (cmd.fin) begin
      out_in_range     <= 1'b0;
      out_bin_overflow <= 1'b0;
      out_bin_number   <= '0;
      out_bin_count    <= '0;
      out_bin_mass     <= '0;
      out_outside_count <= outl_r;
      out_frames_seen  <= frm_r;
    end
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_one_writer, clk, rst_n, cmd.upd, !cmd.clr_step, "update during clear")
  `ASSERT_NEXT(a_clr_zero, clk, rst_n, cmd.clr_init, outl_r == 32'd0 && frm_r == 24'd0, "counters not cleared")
  `ASSERT_IMPL(a_div_nonzero, clk, rst_n, cmd.div_step, dvs_r != '0, "zero divisor")

endmodule

/* hdl/radial_mass_histogram_core.sv */
// ----------------------------------------------------------------------------
// radial_mass_histogram_core
// Radial count/mass histogram of atoms around a configured center.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_*): one beat per operation: add atom, read bin, clear.
//  - Output channel (out_*): exactly one result beat per input beat, in order.
//  - Config channel (cfg_*): index 0..4 = center x/y/z, bin width, cutoff^2.
//    Write only while idle; always ready.
// Operation sequence (accept to out_valid):
//  - add inside cutoff: 3 squares, compare, 26 isqrt steps and a done
//    check, 26 divide steps and a done check, store read and update.
//  - add outside cutoff: 3 squares, compare, result; read: store read and
//    update; clear: sweep of one bin per cycle; unused op: result only.
// One operation at a time; the next beat is taken once the result register
// is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous) clears config, counters and control, then
// sweeps the bin stores to zero (in_ready low, no beat).
// A stalled receiver simply holds the result; no state is lost.
// ----------------------------------------------------------------------------
module radial_mass_histogram_core #(
  parameter int unsigned NUM_BINS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic [15:0]        in_atom_mass,
  input  logic               in_last_in_frame,
  input  logic [7:0]         in_read_bin,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_in_range,
  output logic [7:0]         out_bin_number,
  output logic [31:0]        out_bin_count,
  output logic [47:0]        out_bin_mass,
  output logic [31:0]        out_outside_count,
  output logic [23:0]        out_frames_seen,
  output logic               out_bin_overflow,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int unsigned BinAw = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  rmh_pkg::cmd_t cmd;
  rmh_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  rmh_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_func,
    .out_valid, .out_ready, .cmd, .sts
  );

  rmh_dp #(.NUM_BINS(NUM_BINS), .BIN_AW(BinAw)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .cfg_we(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .in_func, .in_pos_x, .in_pos_y, .in_pos_z, .in_atom_mass,
    .in_last_in_frame, .in_read_bin,
    .out_in_range, .out_bin_number, .out_bin_count, .out_bin_mass,
    .out_outside_count, .out_frames_seen, .out_bin_overflow
  );

endmodule
